/* rtl/core/dhtli_pkg.sv */
// ----------------------------------------------------------------------------
// dhtli_pkg
// Shared types and constants for the double-hashing lookup/insert table.
// ----------------------------------------------------------------------------
package dhtli_pkg;

    localparam int KEY_W     = 31;
    localparam int SLOT_W    = 4;
    localparam int STEP_BASE = 7;
    localparam int STEP_W    = 3;
    localparam int SLOTS_DEF = 16;

    localparam logic ACT_SEARCH = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_DONE
    } dhtli_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MUL_S,
        HS_MUL_7,
        HS_REM_7
    } dhtli_hash_state_t;

endpackage

/* rtl/core/dhtli_hash.sv */
// ----------------------------------------------------------------------------
// dhtli_hash
// Remainder unit: key mod SLOTS and key mod 7 by reciprocal multiplication
// through one shared multiplier, one product a cycle.
// ----------------------------------------------------------------------------
module dhtli_hash
    import dhtli_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [KEY_W-1:0]          key,
    output logic                      done,
    output logic [$clog2(SLOTS)-1:0]  rem_slots,
    output logic [STEP_W-1:0]         rem_step
);

    localparam int IW     = $clog2(SLOTS);
    localparam int MUL_W  = 32;
    localparam int PROD_W = KEY_W + MUL_W;
    localparam int SH_S   = KEY_W + IW;
    localparam int SH_7   = KEY_W + STEP_W;
    localparam int QS_W   = PROD_W - SH_S;
    localparam int Q7_W   = PROD_W - SH_7;
    localparam logic [MUL_W-1:0] RECIP_S = MUL_W'((64'd1 << SH_S) / 64'(SLOTS));
    localparam logic [MUL_W-1:0] RECIP_7 = MUL_W'((64'd1 << SH_7) / 64'(STEP_BASE));

    dhtli_hash_state_t state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [IW-1:0]     rem_s_reg, rem_s_next;
    logic [STEP_W-1:0] rem_7_reg, rem_7_next;
    logic              done_reg, done_next;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod_mul;
    logic [QS_W-1:0]   q_s;
    logic [Q7_W-1:0]   q_7;
    logic [31:0]       diff_s;
    logic [31:0]       diff_7;

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        prod_next  = prod_reg;
        rem_s_next = rem_s_reg;
        rem_7_next = rem_7_reg;
        done_next  = 1'b0;

        mul_b    = (state_reg == HS_MUL_7) ? RECIP_7 : RECIP_S;
        prod_mul = PROD_W'(key_reg) * PROD_W'(mul_b);

        q_s    = prod_reg[PROD_W-1:SH_S];
        diff_s = 32'(key_reg) - 32'(q_s) * 32'(SLOTS);
        if (diff_s >= 32'(SLOTS))
        begin
            diff_s = diff_s - 32'(SLOTS);
        end
        q_7    = prod_reg[PROD_W-1:SH_7];
        diff_7 = 32'(key_reg) - 32'(q_7) * 32'(STEP_BASE);
        if (diff_7 >= 32'(STEP_BASE))
        begin
            diff_7 = diff_7 - 32'(STEP_BASE);
        end

        case (state_reg)
            HS_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    state_next = HS_MUL_S;
                end
            end
            HS_MUL_S:
            begin
                prod_next  = prod_mul;
                state_next = HS_MUL_7;
            end
            HS_MUL_7:
            begin
                rem_s_next = diff_s[IW-1:0];
                prod_next  = prod_mul;
                state_next = HS_REM_7;
            end
            HS_REM_7:
            begin
                rem_7_next = diff_7[STEP_W-1:0];
                done_next  = 1'b1;
                state_next = HS_IDLE;
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        prod_reg  <= prod_next;
        rem_s_reg <= rem_s_next;
        rem_7_reg <= rem_7_next;
    end

    assign done      = done_reg;
    assign rem_slots = rem_s_reg;
    assign rem_step  = rem_7_reg;

endmodule

/* rtl/core/dhtli_table.sv */
// ----------------------------------------------------------------------------
// dhtli_table
// Slot memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dhtli_table
    import dhtli_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [$clog2(SLOTS)-1:0]  rd_addr,
    output logic [KEY_W-1:0]          rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(SLOTS)-1:0]  wr_addr,
    input  logic [KEY_W-1:0]          wr_data,
    output logic                      ready
);

    localparam int IW = $clog2(SLOTS);

    logic [KEY_W-1:0] mem [SLOTS];
    logic [KEY_W-1:0] rd_data_reg;
    logic             clr_busy_reg, clr_busy_next;
    logic [IW-1:0]    clr_addr_reg, clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IW'(SLOTS-1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

/* rtl/core/double_hash_table_lookup_insert_top.sv */
// ----------------------------------------------------------------------------
// double_hash_table_lookup_insert_top
// Open-addressed hash table with double hashing: search or insert one key.
// ----------------------------------------------------------------------------
// Each request item carries an action (search or insert) and a 31-bit key.
// Each request gives exactly one response item: status and slot index.
// The home slot is key mod SLOTS, the probe step 7 - (key mod 7).
// A zero key goes to the response without hashing. Otherwise one shared
// multiplier forms both remainders, then the table is probed one slot a
// cycle through the registered memory read port, at most SLOTS probes, and
// the result is loaded into the response register.
// One item is in work at a time; req_stall is high while it is. The next
// request is taken at the earliest in the cycle after the response is
// loaded. After reset the memory is cleared one slot a cycle; req_stall
// stays high until the sweep is done.
// The response register holds while rsp_stall is high; a new request may be
// taken meanwhile and its response waits until the register is free.
// ----------------------------------------------------------------------------
module double_hash_table_lookup_insert_top
    import dhtli_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int SW = IW + 4;

    dhtli_state_t     state_reg, state_next;
    logic             action_reg, action_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [STEP_W-1:0] stride_reg, stride_next;
    logic [IW-1:0]    cnt_reg, cnt_next;
    rsp_item_t        res_reg, res_next;
    rsp_item_t        rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             hash_start;
    logic             hash_done;
    logic [IW-1:0]    hash_rem_slots;
    logic [STEP_W-1:0] hash_rem_step;

    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic             tbl_ready;

    logic [SW-1:0]    step_sum;
    logic [IW-1:0]    pos_adv;
    logic [SW-1:0]    pos_wide;

    dhtli_hash #(.SLOTS(SLOTS)) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (hash_start),
        .key       (req.key),
        .done      (hash_done),
        .rem_slots (hash_rem_slots),
        .rem_step  (hash_rem_step)
    );

    dhtli_table #(.SLOTS(SLOTS)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (key_reg),
        .ready   (tbl_ready)
    );

    always_comb
    begin
        step_sum = SW'(pos_reg) + SW'(stride_reg);
        for (int i = 0; i < 4; i++)
        begin
            if (step_sum >= SW'(SLOTS))
            begin
                step_sum = step_sum - SW'(SLOTS);
            end
        end
        pos_adv  = step_sum[IW-1:0];
        pos_wide = SW'(pos_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        stride_next    = stride_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        hash_start     = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = pos_reg;
        req_stall      = (state_reg != ST_IDLE) || !tbl_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    action_next = req.action;
                    key_next    = req.key;
                    if (req.key == '0)
                    begin
                        res_next   = '{status: STATUS_NOT_FOUND, slot: '0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    rd_addr     = hash_rem_slots;
                    pos_next    = hash_rem_slots;
                    stride_next = STEP_W'(STEP_BASE) - hash_rem_step;
                    cnt_next    = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (action_reg == ACT_SEARCH && rd_data == '0)
                begin
                    res_next   = '{status: STATUS_NOT_FOUND, slot: '0};
                    state_next = ST_DONE;
                end
                else if (action_reg == ACT_SEARCH && rd_data == key_reg)
                begin
                    res_next   = '{status: STATUS_OK, slot: pos_wide[SLOT_W-1:0]};
                    state_next = ST_DONE;
                end
                else if (action_reg == ACT_INSERT && rd_data == '0)
                begin
                    wr_en      = 1'b1;
                    res_next   = '{status: STATUS_OK, slot: pos_wide[SLOT_W-1:0]};
                    state_next = ST_DONE;
                end
                else if (cnt_reg == IW'(SLOTS-1))
                begin
                    res_next.status = (action_reg == ACT_SEARCH) ? STATUS_NOT_FOUND
                                                                 : STATUS_FULL;
                    res_next.slot   = '0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd_addr  = pos_adv;
                    pos_next = pos_adv;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        stride_reg <= stride_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* verif/double_hash_table_lookup_insert_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_lookup_insert_top_tb
// Checks search and insert of keys in the double-hashing table. A directed
// table covers the key extremes, the zero key, duplicates, a short probe
// path running out and a full path. A random mix over a small pool of keys
// with shared home slots follows. Each response is compared with a predictor
// that keeps its own copy of the table, or with the row for typed rows.
// ----------------------------------------------------------------------------
module double_hash_table_lookup_insert_top_tb;
    import dhtli_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 150;
    localparam int POOL_SIZE    = 24;
    localparam int N_DIRECTED   = 24;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
        logic               typed;
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ACT_SEARCH, 31'd5,          1'b1, STATUS_NOT_FOUND, 4'd0},
        '{ACT_SEARCH, 31'd0,          1'b1, STATUS_NOT_FOUND, 4'd0},
        '{ACT_INSERT, 31'd0,          1'b1, STATUS_NOT_FOUND, 4'd0},
        '{ACT_INSERT, 31'd5,          1'b1, STATUS_OK,        4'd5},
        '{ACT_SEARCH, 31'd5,          1'b1, STATUS_OK,        4'd5},
        '{ACT_INSERT, KEY_MAX,        1'b1, STATUS_OK,        4'd15},
        '{ACT_SEARCH, KEY_MAX,        1'b1, STATUS_OK,        4'd15},
        '{ACT_INSERT, 31'd3,          1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd115,        1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd227,        1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd339,        1'b1, STATUS_FULL,      4'd0},
        '{ACT_SEARCH, 31'd339,        1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'd227,        1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd5,          1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'd5,          1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd16,         1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'd32,         1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd1,          1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd2,          1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'h4000_0000,  1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'h2AAA_AAAA,  1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'h5555_5555,  1'b0, STATUS_OK,        4'd0},
        '{ACT_INSERT, 31'd10,         1'b0, STATUS_OK,        4'd0},
        '{ACT_SEARCH, 31'd10,         1'b0, STATUS_OK,        4'd0}
    };

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    logic [KEY_W-1:0] stored_keys [SLOTS];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    rsp_item_t        pending_rsp_q [$];
    int               n_errors;
    int               n_sent;
    int               idle_cycles;
    bit               no_gaps;

    double_hash_table_lookup_insert_top #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_item_t probe_table(logic action, logic [KEY_W-1:0] key);
        rsp_item_t   r;
        int unsigned k;
        int unsigned pos;
        int unsigned stride;
        r.status = STATUS_NOT_FOUND;
        r.slot   = '0;
        k        = 32'(key);
        if (k == 0)
            return r;
        pos    = k % SLOTS;
        stride = STEP_BASE - (k % STEP_BASE);
        for (int probe = 0; probe < SLOTS; probe++)
        begin
            if (action == ACT_SEARCH)
            begin
                if (stored_keys[pos] == '0)
                    return r;
                if (stored_keys[pos] == key)
                begin
                    r.status = STATUS_OK;
                    r.slot   = pos[SLOT_W-1:0];
                    return r;
                end
            end
            else if (stored_keys[pos] == '0)
            begin
                stored_keys[pos] = key;
                r.status         = STATUS_OK;
                r.slot           = pos[SLOT_W-1:0];
                return r;
            end
            pos = (pos + stride) % SLOTS;
        end
        if (action == ACT_INSERT)
            r.status = STATUS_FULL;
        return r;
    endfunction

    task automatic send_item(req_item_t item, bit typed, rsp_item_t typed_rsp);
        int        gap;
        rsp_item_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = probe_table(item.action, item.key);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
        n_sent++;
    endtask

    function automatic req_item_t random_item();
        req_item_t item;
        int        pick;
        item.action = ($urandom_range(0, 99) < 15) ? ACT_INSERT : ACT_SEARCH;
        pick        = $urandom_range(0, 99);
        if (pick < 3)
            item.key = '0;
        else if (pick < 6)
            item.key = KEY_MAX;
        else if (pick < 72)
            item.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            item.key = KEY_W'($urandom());
        return item;
    endfunction

    // drive stimulus
    initial
    begin
        req_item_t item;
        rsp_item_t typed_rsp;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        n_errors  = 0;
        n_sent    = 0;
        no_gaps   = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            stored_keys[i] = '0;
        // keys sharing home slot and step collide along one path
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < POOL_SIZE / 2) ? 31'(112 * i + 13 * (i % 3) + 1)
                                              : 31'($urandom());
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
        begin
            item.action      = DIRECTED_ROWS[i].action;
            item.key         = DIRECTED_ROWS[i].key;
            typed_rsp.status = DIRECTED_ROWS[i].status;
            typed_rsp.slot   = DIRECTED_ROWS[i].slot;
            send_item(item, DIRECTED_ROWS[i].typed, typed_rsp);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            send_item(random_item(), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("[double_hash_table_lookup_insert_top] OK");
        else
            $display("[double_hash_table_lookup_insert_top] ERROR");
        $finish;
    end

    // drive response stall
    initial
    begin
        int  hold;
        bit  held_long;
        rsp_stall = 1'b0;
        held_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_long && n_sent >= HOLD_AT_ITEM)
            begin
                held_long = 1'b1;
                hold      = HOLD_CYCLES;
            end
            else
                hold = no_gaps ? 0 : $urandom_range(0, 16);
            if (hold != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // check responses and watch for a hang
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[double_hash_table_lookup_insert_top] ERROR");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    $error("unexpected item: status %0d slot %0d", rsp.status, rsp.slot);
                    n_errors++;
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        n_errors++;
                    end
                    if (rsp.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                        n_errors++;
                    end
                end
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule
